[hw/rtl/signed_run_length_encoder_top_defines.svh]
`ifndef SIGNED_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH
`define SIGNED_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH

// Checked only out of reset; needs clk and rst_n in scope.
`define SRLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SRLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/srle_pkg.sv]
package srle_pkg;

    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 6;
    localparam int RUN_LIMIT_DEF = 63;

    // Per-cycle command to the literal cell chain.
    typedef struct packed {
        logic              append;
        logic              shift;
        logic [CNT_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } cell_ctl_t;

endpackage

[hw/rtl/signed_run_length_encoder_top.sv]
// Signed-count run-length encoder, one byte per input item, end of stream on s_axis_tlast.
// Repeats of two or more come out as a positive count byte then the byte; literals come out
// as count 1 (lone byte) or a negative count then the bytes. cfg_wdata sets the longest run
// (2..RUN_LIMIT, clamped); the user is to write it only while idle, the block does not enforce it.
// An item holds off input till all its result bytes enter the single output byte register;
// literal bytes drain one per cycle when not stalled, head first, from RUN_LIMIT shift cells.
// m_axis_tlast marks the last result of an item, m_axis_tuser the last result of the stream.
module signed_run_length_encoder_top #(
    parameter int RUN_LIMIT = srle_pkg::RUN_LIMIT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [srle_pkg::CNT_W-1:0]  cfg_wdata,     // max_run
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [srle_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] in_byte
    input  logic                        s_axis_tlast,  // end_of_data
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [srle_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] out_byte
    output logic                        m_axis_tlast,  // last_of_burst
    output logic                        m_axis_tuser   // [0] stream_done
);
    import srle_pkg::*;

    cell_ctl_t         cell_ctl;
    logic [BYTE_W-1:0] cell_q [RUN_LIMIT];

    srle_ctrl #(
        .RUN_LIMIT(RUN_LIMIT)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cell_head     (cell_q[0]),
        .cell_ctl      (cell_ctl)
    );

    for (genvar i = 0; i < RUN_LIMIT; i++)
    begin : g_cell
        logic [BYTE_W-1:0] nb;
        if (i == RUN_LIMIT - 1)
        begin : g_end
            assign nb = '0;
        end
        else
        begin : g_mid
            assign nb = cell_q[i+1];
        end

        srle_cell #(
            .INDEX(i)
        ) u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .next_byte (nb),
            .cell_byte (cell_q[i])
        );
    end

endmodule

[hw/rtl/srle_cell.sv]
module srle_cell #(
    parameter int INDEX = 0
) (
    input  logic                       clk,
    input  srle_pkg::cell_ctl_t        ctl,
    input  logic [srle_pkg::BYTE_W-1:0] next_byte,
    output logic [srle_pkg::BYTE_W-1:0] cell_byte
);
    import srle_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // Drain moves every byte one cell toward the head; append lands at the tail index.
    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.shift)
        begin
            byte_next = next_byte;
        end
        else if (ctl.append && (ctl.idx == CNT_W'(INDEX)))
        begin
            byte_next = ctl.data;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

[hw/rtl/srle_ctrl.sv]
`include "signed_run_length_encoder_top_defines.svh"

module srle_ctrl #(
    parameter int RUN_LIMIT = srle_pkg::RUN_LIMIT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [srle_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [srle_pkg::BYTE_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [srle_pkg::BYTE_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser,
    input  logic [srle_pkg::BYTE_W-1:0] cell_head,
    output srle_pkg::cell_ctl_t         cell_ctl
);
    import srle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REP_CNT,
        S_REP_VAL,
        S_LIT_HDR,
        S_LIT_BODY,
        S_LIT_TAIL
    } state_t;

    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(RUN_LIMIT);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MIN_RUN = CNT_W'(2);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  max_run_reg, max_run_next;

    // encoder state
    logic [CNT_W-1:0]  rep_cnt_reg, rep_cnt_next;
    logic [BYTE_W-1:0] rep_val_reg, rep_val_next;
    logic [BYTE_W-1:0] held_b_reg, held_b_next;
    logic              held_v_reg, held_v_next;
    logic [CNT_W-1:0]  lit_cnt_reg, lit_cnt_next;

    // emission snapshot
    logic [CNT_W-1:0]  rcnt_reg, rcnt_next;
    logic [BYTE_W-1:0] rval_reg, rval_next;
    logic [BYTE_W-1:0] hdr_reg, hdr_next;
    logic [CNT_W-1:0]  drain_reg, drain_next;
    logic              tail_v_reg, tail_v_next;
    logic [BYTE_W-1:0] tail_reg, tail_next;
    logic              rep_pend_reg, rep_pend_next;
    logic              lit_pend_reg, lit_pend_next;
    logic              end_reg, end_next;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_user_reg, m_user_next;

    // step results
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  c_rep_cnt, c_lit_cnt;
    logic [BYTE_W-1:0] c_rep_val, c_held_b;
    logic              c_held_v;
    logic              r_emit, l_emit, l_first, l_tail_v, app;
    logic [CNT_W-1:0]  r_cnt, l_drain;
    logic [BYTE_W-1:0] r_val, l_tail;
    logic [CNT_W:0]    l_n;
    logic [BYTE_W-1:0] l_hdr;

    logic              accept, out_free, out_load, out_last;
    logic [BYTE_W-1:0] out_data;

    assign accept   = s_axis_tvalid && (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        if (max_run_reg < MIN_RUN)
        begin
            lim = MIN_RUN;
        end
        else if (max_run_reg > LIMIT_C)
        begin
            lim = LIMIT_C;
        end
        else
        begin
            lim = max_run_reg;
        end
    end

    // One item's effect on the encoder state and which runs it releases.
    always_comb
    begin
        c_rep_cnt = rep_cnt_reg;
        c_rep_val = rep_val_reg;
        c_held_b  = held_b_reg;
        c_held_v  = held_v_reg;
        c_lit_cnt = lit_cnt_reg;
        r_emit    = 1'b0;
        r_cnt     = rep_cnt_reg;
        r_val     = rep_val_reg;
        l_emit    = 1'b0;
        l_first   = 1'b0;
        l_drain   = lit_cnt_reg;
        l_tail_v  = 1'b0;
        l_tail    = held_b_reg;
        app       = 1'b0;
        if (rep_cnt_reg != '0)
        begin
            if (s_axis_tdata == rep_val_reg)
            begin
                c_rep_cnt = (rep_cnt_reg == CNT_MAX) ? rep_cnt_reg : rep_cnt_reg + 1'b1;
                if (c_rep_cnt >= lim)
                begin
                    r_emit    = 1'b1;
                    r_cnt     = c_rep_cnt;
                    c_rep_cnt = '0;
                end
            end
            else
            begin
                r_emit    = 1'b1;
                c_rep_cnt = '0;
                c_held_b  = s_axis_tdata;
                c_held_v  = 1'b1;
            end
        end
        else if (held_v_reg)
        begin
            if (s_axis_tdata == held_b_reg)
            begin
                // held byte repeats: literals before it go out first
                if (lit_cnt_reg != '0)
                begin
                    l_emit  = 1'b1;
                    l_first = 1'b1;
                end
                c_lit_cnt = '0;
                c_held_v  = 1'b0;
                c_rep_val = s_axis_tdata;
                c_rep_cnt = MIN_RUN;
                if (lim == MIN_RUN)
                begin
                    r_emit    = 1'b1;
                    r_cnt     = MIN_RUN;
                    r_val     = s_axis_tdata;
                    c_rep_cnt = '0;
                end
            end
            else
            begin
                if (lit_cnt_reg < LIMIT_C)
                begin
                    app       = 1'b1;
                    c_lit_cnt = lit_cnt_reg + 1'b1;
                end
                c_held_b = s_axis_tdata;
                if (({1'b0, c_lit_cnt} + 1'b1) >= {1'b0, lim})
                begin
                    l_emit    = 1'b1;
                    l_drain   = c_lit_cnt;
                    l_tail_v  = 1'b1;
                    l_tail    = s_axis_tdata;
                    c_lit_cnt = '0;
                    c_held_v  = 1'b0;
                end
            end
        end
        else
        begin
            c_held_b = s_axis_tdata;
            c_held_v = 1'b1;
            if (({1'b0, lit_cnt_reg} + 1'b1) >= {1'b0, lim})
            begin
                l_emit    = 1'b1;
                l_drain   = lit_cnt_reg;
                l_tail_v  = 1'b1;
                l_tail    = s_axis_tdata;
                c_lit_cnt = '0;
                c_held_v  = 1'b0;
            end
        end
        if (s_axis_tlast)
        begin
            if (c_rep_cnt != '0)
            begin
                r_emit = 1'b1;
                r_cnt  = c_rep_cnt;
                r_val  = c_rep_val;
            end
            if ((c_lit_cnt != '0) || c_held_v)
            begin
                l_emit   = 1'b1;
                l_drain  = c_lit_cnt;
                l_tail_v = c_held_v;
                l_tail   = c_held_b;
            end
            c_rep_cnt = '0;
            c_rep_val = '0;
            c_held_b  = '0;
            c_held_v  = 1'b0;
            c_lit_cnt = '0;
        end
    end

    // Literal header: count 1 for a lone byte, else minus the run length.
    assign l_n   = {1'b0, l_drain} + {{CNT_W{1'b0}}, l_tail_v};
    assign l_hdr = (l_n == (CNT_W+1)'(1)) ? BYTE_W'(1) : BYTE_W'(~{1'b0, l_n} + 1'b1);

    always_comb
    begin
        state_next    = state_reg;
        max_run_next  = cfg_we ? cfg_wdata : max_run_reg;
        rep_cnt_next  = rep_cnt_reg;
        rep_val_next  = rep_val_reg;
        held_b_next   = held_b_reg;
        held_v_next   = held_v_reg;
        lit_cnt_next  = lit_cnt_reg;
        rcnt_next     = rcnt_reg;
        rval_next     = rval_reg;
        hdr_next      = hdr_reg;
        drain_next    = drain_reg;
        tail_v_next   = tail_v_reg;
        tail_next     = tail_reg;
        rep_pend_next = rep_pend_reg;
        lit_pend_next = lit_pend_reg;
        end_next      = end_reg;
        out_load      = 1'b0;
        out_data      = hdr_reg;
        out_last      = 1'b0;
        cell_ctl      = '{append: 1'b0, shift: 1'b0, idx: lit_cnt_reg, data: held_b_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rep_cnt_next    = c_rep_cnt;
                    rep_val_next    = c_rep_val;
                    held_b_next     = c_held_b;
                    held_v_next     = c_held_v;
                    lit_cnt_next    = c_lit_cnt;
                    rcnt_next       = r_cnt;
                    rval_next       = r_val;
                    hdr_next        = l_hdr;
                    drain_next      = l_drain;
                    tail_v_next     = l_tail_v;
                    tail_next       = l_tail;
                    end_next        = s_axis_tlast;
                    cell_ctl.append = app;
                    // pend flags mark only the second run of the item
                    rep_pend_next   = 1'b0;
                    lit_pend_next   = 1'b0;
                    if (l_emit && l_first)
                    begin
                        state_next    = S_LIT_HDR;
                        rep_pend_next = r_emit;
                    end
                    else if (r_emit)
                    begin
                        state_next    = S_REP_CNT;
                        lit_pend_next = l_emit;
                    end
                    else if (l_emit)
                    begin
                        state_next = S_LIT_HDR;
                    end
                end
            end
            S_REP_CNT:
            begin
                out_data = BYTE_W'(rcnt_reg);
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_REP_VAL;
                end
            end
            S_REP_VAL:
            begin
                out_data = rval_reg;
                out_last = !lit_pend_reg;
                if (out_free)
                begin
                    out_load      = 1'b1;
                    lit_pend_next = 1'b0;
                    state_next    = lit_pend_reg ? S_LIT_HDR : S_IDLE;
                end
            end
            S_LIT_HDR:
            begin
                out_data = hdr_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = (drain_reg != '0) ? S_LIT_BODY : S_LIT_TAIL;
                end
            end
            S_LIT_BODY:
            begin
                out_data = cell_head;
                out_last = (drain_reg == CNT_W'(1)) && !tail_v_reg && !rep_pend_reg;
                if (out_free)
                begin
                    out_load       = 1'b1;
                    cell_ctl.shift = 1'b1;
                    drain_next     = drain_reg - 1'b1;
                    if (drain_reg == CNT_W'(1))
                    begin
                        if (tail_v_reg)
                        begin
                            state_next = S_LIT_TAIL;
                        end
                        else
                        begin
                            rep_pend_next = 1'b0;
                            state_next    = rep_pend_reg ? S_REP_CNT : S_IDLE;
                        end
                    end
                end
            end
            S_LIT_TAIL:
            begin
                out_data = tail_reg;
                out_last = !rep_pend_reg;
                if (out_free)
                begin
                    out_load      = 1'b1;
                    rep_pend_next = 1'b0;
                    state_next    = rep_pend_reg ? S_REP_CNT : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
        m_data_next  = out_load ? out_data : m_data_reg;
        m_last_next  = out_load ? out_last : m_last_reg;
        m_user_next  = out_load ? (out_last && end_reg) : m_user_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            max_run_reg  <= LIMIT_C;
            rep_cnt_reg  <= '0;
            rep_val_reg  <= '0;
            held_b_reg   <= '0;
            held_v_reg   <= 1'b0;
            lit_cnt_reg  <= '0;
            rcnt_reg     <= '0;
            rval_reg     <= '0;
            hdr_reg      <= '0;
            drain_reg    <= '0;
            tail_v_reg   <= 1'b0;
            tail_reg     <= '0;
            rep_pend_reg <= 1'b0;
            lit_pend_reg <= 1'b0;
            end_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            m_last_reg   <= 1'b0;
            m_user_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            max_run_reg  <= max_run_next;
            rep_cnt_reg  <= rep_cnt_next;
            rep_val_reg  <= rep_val_next;
            held_b_reg   <= held_b_next;
            held_v_reg   <= held_v_next;
            lit_cnt_reg  <= lit_cnt_next;
            rcnt_reg     <= rcnt_next;
            rval_reg     <= rval_next;
            hdr_reg      <= hdr_next;
            drain_reg    <= drain_next;
            tail_v_reg   <= tail_v_next;
            tail_reg     <= tail_next;
            rep_pend_reg <= rep_pend_next;
            lit_pend_reg <= lit_pend_next;
            end_reg      <= end_next;
            m_valid_reg  <= m_valid_next;
            m_data_reg   <= m_data_next;
            m_last_reg   <= m_last_next;
            m_user_reg   <= m_user_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    `SRLE_ASSERT(a_idle_no_pend, s_axis_tready |-> (!rep_pend_reg && !lit_pend_reg), "run left pending at idle")
    `SRLE_ASSERT(a_body_has_bytes, (state_reg == S_LIT_BODY) |-> (drain_reg != '0), "literal drain with empty chain")
    `SRLE_ASSERT(a_done_is_last, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "stream end not on last item")
    `SRLE_ASSERT_ALWAYS(a_rep_min_two, rep_cnt_reg != CNT_W'(1), "repeat run of one")
    `SRLE_ASSERT(a_lit_needs_held, !held_v_reg |-> (lit_cnt_reg == '0), "stored literals without held byte")

endmodule

[test/signed_run_length_encoder_top_tb.sv]
module signed_run_length_encoder_top_tb;

    import srle_pkg::*;

    localparam int RUN_LIMIT = RUN_LIMIT_DEF;
    localparam int SETTLE_CYCLES = 70;   // one item may hold the block while its result bytes go out

    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_burst;
        logic              stream_done;
    } coded_byte_t;

    class packbits_checker;
        logic [BYTE_W-1:0] literal_bytes [RUN_LIMIT];
        int                literal_cnt;
        logic [BYTE_W-1:0] repeat_val;
        int                repeat_cnt;
        logic [BYTE_W-1:0] held;
        bit                held_ok;
        logic [CNT_W-1:0]  max_run;
        logic [BYTE_W-1:0] burst [$];
        coded_byte_t       encoded_q [$];
        int                errors;
        int                n_items;
        int                n_results;
        int                n_streams;

        function new();
            literal_cnt = 0;
            repeat_val  = '0;
            repeat_cnt  = 0;
            held        = '0;
            held_ok     = 1'b0;
            max_run     = CNT_W'(RUN_LIMIT);
            errors      = 0;
            n_items     = 0;
            n_results   = 0;
            n_streams   = 0;
        endfunction

        function void set_max_run(logic [CNT_W-1:0] v);
            max_run = v;
        endfunction

        function int pending();
            return encoded_q.size();
        endfunction

        function void emit(logic [BYTE_W-1:0] b);
            burst.push_back(b);
        endfunction

        function void flush_repeat();
            if (repeat_cnt > 0)
            begin
                emit(BYTE_W'(repeat_cnt));
                emit(repeat_val);
                repeat_cnt = 0;
            end
        endfunction

        function void flush_literals();
            int n;
            n = literal_cnt + (held_ok ? 1 : 0);
            if (n == 0)
                return;
            if (n == 1)
            begin
                emit(BYTE_W'(1));
                emit(held_ok ? held : literal_bytes[0]);
            end
            else
            begin
                emit(BYTE_W'(256 - n));   // negative count, two's complement
                for (int i = 0; i < literal_cnt; i++)
                    emit(literal_bytes[i]);
                if (held_ok)
                    emit(held);
            end
            literal_cnt = 0;
            held_ok     = 1'b0;
        endfunction

        // Called for every accepted input item; queues the bytes it releases.
        function void encode_byte(logic [BYTE_W-1:0] b, bit eod);
            int          lim;
            coded_byte_t c;
            lim = (max_run < 2) ? 2 : ((max_run > RUN_LIMIT) ? RUN_LIMIT : int'(max_run));
            burst.delete();
            n_items++;
            if (repeat_cnt > 0)
            begin
                if (b == repeat_val)
                begin
                    if (repeat_cnt < 63)
                        repeat_cnt++;
                    if (repeat_cnt >= lim)
                        flush_repeat();
                end
                else
                begin
                    flush_repeat();
                    held    = b;
                    held_ok = 1'b1;
                end
            end
            else if (held_ok)
            begin
                if (b == held)
                begin
                    held_ok = 1'b0;
                    flush_literals();
                    repeat_val = b;
                    repeat_cnt = 2;
                    if (repeat_cnt >= lim)
                        flush_repeat();
                end
                else
                begin
                    if (literal_cnt < RUN_LIMIT)
                    begin
                        literal_bytes[literal_cnt] = held;
                        literal_cnt++;
                    end
                    held = b;
                    if (literal_cnt + 1 >= lim)
                        flush_literals();
                end
            end
            else
            begin
                held    = b;
                held_ok = 1'b1;
                if (literal_cnt + 1 >= lim)
                    flush_literals();
            end
            if (eod)
            begin
                flush_repeat();
                flush_literals();
                repeat_val = '0;
                held       = '0;
                n_streams++;
            end
            foreach (burst[i])
            begin
                c.out_byte      = burst[i];
                c.last_of_burst = (i == burst.size() - 1);
                c.stream_done   = (i == burst.size() - 1) && eod;
                encoded_q.push_back(c);
            end
        endfunction

        function void check_result(logic [BYTE_W-1:0] ob, logic lb, logic sd);
            coded_byte_t c;
            n_results++;
            if (encoded_q.size() == 0)
            begin
                $error("unexpected result: out_byte=%0h last_of_burst=%0b stream_done=%0b",
                       ob, lb, sd);
                errors++;
                return;
            end
            c = encoded_q.pop_front();
            if (ob !== c.out_byte)
            begin
                $error("out_byte: expected %0h, got %0h", c.out_byte, ob);
                errors++;
            end
            if (lb !== c.last_of_burst)
            begin
                $error("last_of_burst: expected %0b, got %0b", c.last_of_burst, lb);
                errors++;
            end
            if (sd !== c.stream_done)
            begin
                $error("stream_done: expected %0b, got %0b", c.stream_done, sd);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [BYTE_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;

    packbits_checker sb;
    bit              quiet;
    bit              rx_live;

    signed_run_length_encoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("signed_run_length_encoder_top verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // Result side: ready with random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        wait (rx_live);
        forever
        begin
            @(posedge clk);
            if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic wait_results_in();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Valid stays up after acceptance; the next send either overwrites or idles it.
    task automatic send_item(input logic [BYTE_W-1:0] b, input bit eod);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        else if (!quiet && $urandom_range(0, 60) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            wait_results_in();
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eod;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.encode_byte(b, eod);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait_results_in();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_run(input logic [CNT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_max_run(v);
    endtask

    task automatic send_bytes(input logic [BYTE_W-1:0] bytes [$]);
        foreach (bytes[i])
            send_item(bytes[i], i == bytes.size() - 1);
    endtask

    // Mostly runs and literal bursts with random content, some stray stream ends.
    task automatic send_random_stream(input int count, input bit close);
        int                sent;
        int                kind;
        int                len;
        bit                eod;
        logic [BYTE_W-1:0] val;
        logic [BYTE_W-1:0] prev;
        sent = 0;
        prev = 8'($urandom);
        while (sent < count)
        begin
            kind = $urandom_range(0, 19);
            val  = 8'($urandom);
            if (kind < 6)
                len = 1;
            else if (kind < 13)
                len = $urandom_range(2, 6);
            else if (kind < 15)
                len = $urandom_range(7, 70);
            else if (kind < 18)
                len = $urandom_range(2, 12);
            else
                len = $urandom_range(13, 70);
            if (len > count - sent)
                len = count - sent;
            for (int i = 0; i < len; i++)
            begin
                if (kind >= 15 && i > 0)
                    val = prev + 8'($urandom_range(1, 255));   // keep literal bytes distinct
                eod = (close && sent == count - 1) || ($urandom_range(0, 59) == 0);
                send_item(val, eod);
                prev = val;
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [CNT_W-1:0] run_caps [10];
        sb            = new();
        quiet         = 1'b0;
        rx_live       = 1'b0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n   <= 1'b1;
        rx_live = 1'b1;
        @(posedge clk);

        write_max_run(6'd63);
        // lone bytes at both extremes, a repeat, a literal burst, repeat then lone literal,
        // lone literal ahead of a repeat
        send_bytes('{8'h00});
        send_bytes('{8'hFF});
        send_bytes('{8'h55, 8'h55, 8'h55});
        send_bytes('{8'h01, 8'h02, 8'h80});
        send_bytes('{8'hAA, 8'hAA, 8'h7F});
        send_bytes('{8'h10, 8'h20, 8'h20, 8'h20});
        settle();

        // capped run restarts afresh on an equal byte
        write_max_run(6'd2);
        send_bytes('{8'h33, 8'h33, 8'h33, 8'h44});
        settle();
        // below the legal range acts as 2
        write_max_run(6'd0);
        send_bytes('{8'h9C, 8'h9D});
        settle();

        // unclosed phases leave a stream pending across the next limit change
        run_caps = '{6'd63, 6'd1, 6'd17, 6'd2, 6'd63, 6'd5, 6'd40, 6'd3, 6'd63, 6'd2};
        foreach (run_caps[p])
        begin
            if (p >= 8)
                quiet = 1'b1;
            write_max_run(run_caps[p]);
            send_random_stream(36, (p == 9) || ($urandom_range(0, 1) == 0));
            settle();
        end

        $display("%0d items in %0d streams encoded into %0d bytes, with run limits",
                 sb.n_items, sb.n_streams, sb.n_results);
        $display("from below range to the maximum, changed both between and within streams");
        if (sb.errors == 0)
            $display("signed_run_length_encoder_top verification clean");
        else
            $display("signed_run_length_encoder_top verification failed");
        $finish;
    end

endmodule

[signed_run_length_encoder_top.f]
+incdir+hw/rtl
hw/rtl/srle_pkg.sv
hw/rtl/srle_cell.sv
hw/rtl/srle_ctrl.sv
hw/rtl/signed_run_length_encoder_top.sv
test/signed_run_length_encoder_top_tb.sv
